[rtl/core/gzhp_pkg.sv]
`timescale 1ns / 1ps

package gzhp_pkg;

  // Byte classification carried on the output side.
  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_DISCARD = 2'd2
  } byte_kind_t;

  // Parse status reported with every output transfer.
  typedef enum logic [2:0] {
    ST_HEADER = 3'd0,
    ST_OK     = 3'd1,
    ST_TRANSP = 3'd2,
    ST_BAD    = 3'd3,
    ST_TRUNC  = 3'd4
  } parse_status_t;

  localparam logic [7:0] MAGIC_ID1      = 8'h1f;
  localparam logic [7:0] MAGIC_ID2      = 8'h8b;
  localparam logic [7:0] METHOD_DEFLATE = 8'h08;
  localparam logic [7:0] FLAG_RESERVED  = 8'he0;
  localparam int         FLAG_HCRC_BIT  = 1;
  localparam int         FLAG_EXTRA_BIT = 2;
  localparam int         FLAG_NAME_BIT  = 3;
  localparam int         FLAG_COMM_BIT  = 4;
  localparam logic [15:0] FIXED_SKIP    = 16'd6;
  localparam logic [15:0] HCRC_SKIP     = 16'd2;

  // Default depth of the queue between the classifier and the emitter.
  localparam int QUEUE_DEPTH_DEF = 4;

  // One classified byte as it travels from front to back.
  typedef struct packed {
    logic [7:0]    data;
    byte_kind_t    kind;
    parse_status_t status;
    logic [4:0]    flags;
    logic          dup;    // Emit the held first magic byte ahead of data.
  } gzhp_entry_t;

endpackage

[rtl/core/gzhp_front.sv]
`timescale 1ns / 1ps

module gzhp_front
  import gzhp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        end_of_input,
  input  logic        q_full,
  output logic        q_push,
  output gzhp_entry_t q_entry
);

  typedef enum logic [14:0] {
    PH_MAGIC1   = 15'b000000000000001,
    PH_MAGIC2   = 15'b000000000000010,
    PH_METHOD   = 15'b000000000000100,
    PH_FLAGS    = 15'b000000000001000,
    PH_SKIP6    = 15'b000000000010000,
    PH_XLEN_LO  = 15'b000000000100000,
    PH_XLEN_HI  = 15'b000000001000000,
    PH_EXTRA    = 15'b000000010000000,
    PH_NAME     = 15'b000000100000000,
    PH_COMMENT  = 15'b000001000000000,
    PH_HCRC     = 15'b000010000000000,
    PH_PAYLOAD  = 15'b000100000000000,
    PH_TRANSP   = 15'b001000000000000,
    PH_ERROR    = 15'b010000000000000,
    PH_FLAGSBAD = 15'b100000000000000
  } phase_t;

  typedef struct packed {
    phase_t phase;
    logic   done;
    logic   load_crc;
  } part_sel_t;

  phase_t        phase, phase_next;
  logic [4:0]    saved_flags, saved_flags_next;
  logic [15:0]   skip_remaining, skip_remaining_next;
  parse_status_t final_status, final_status_next;
  logic [15:0]   skip_dec;
  logic          check_trunc;
  part_sel_t     part;

  // Pick the next optional header part at or after the given one.
  function automatic part_sel_t enter_part(input logic [2:0] start, input logic [4:0] flags);
    part_sel_t r;
    r = '{phase: PH_PAYLOAD, done: 1'b1, load_crc: 1'b0};
    if (start <= 3'd0 && flags[FLAG_EXTRA_BIT]) begin
      r = '{phase: PH_XLEN_LO, done: 1'b0, load_crc: 1'b0};
    end else if (start <= 3'd1 && flags[FLAG_NAME_BIT]) begin
      r = '{phase: PH_NAME, done: 1'b0, load_crc: 1'b0};
    end else if (start <= 3'd2 && flags[FLAG_COMM_BIT]) begin
      r = '{phase: PH_COMMENT, done: 1'b0, load_crc: 1'b0};
    end else if (start <= 3'd3 && flags[FLAG_HCRC_BIT]) begin
      r = '{phase: PH_HCRC, done: 1'b0, load_crc: 1'b1};
    end
    return r;
  endfunction

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;
  assign skip_dec = (skip_remaining != 16'd0) ? skip_remaining - 16'd1 : 16'd0;

  // Classify the current byte and work out the next parse state.
  always_comb begin
    phase_next          = phase;
    saved_flags_next    = saved_flags;
    skip_remaining_next = skip_remaining;
    final_status_next   = final_status;
    check_trunc         = 1'b0;
    part                = '{phase: PH_PAYLOAD, done: 1'b1, load_crc: 1'b0};
    q_entry.data        = in_byte;
    q_entry.kind        = KIND_HEADER;
    q_entry.dup         = 1'b0;

    case (phase)
      PH_PAYLOAD, PH_TRANSP: begin
        q_entry.kind = KIND_PAYLOAD;
      end
      PH_MAGIC1: begin
        if (in_byte != MAGIC_ID1) begin
          phase_next        = PH_TRANSP;
          final_status_next = ST_TRANSP;
          q_entry.kind      = KIND_PAYLOAD;
        end else begin
          phase_next  = PH_MAGIC2;
          check_trunc = 1'b1;
        end
      end
      PH_MAGIC2: begin
        if (in_byte != MAGIC_ID2) begin
          phase_next        = PH_TRANSP;
          final_status_next = ST_TRANSP;
          q_entry.kind      = KIND_PAYLOAD;
          q_entry.dup       = 1'b1;
        end else begin
          phase_next  = PH_METHOD;
          check_trunc = 1'b1;
        end
      end
      PH_METHOD: begin
        phase_next  = (in_byte == METHOD_DEFLATE) ? PH_FLAGS : PH_FLAGSBAD;
        check_trunc = 1'b1;
      end
      PH_FLAGS, PH_FLAGSBAD: begin
        saved_flags_next = in_byte[4:0];
        if (phase == PH_FLAGSBAD || (in_byte & FLAG_RESERVED) != 8'd0) begin
          phase_next        = PH_ERROR;
          final_status_next = ST_BAD;
        end else begin
          phase_next          = PH_SKIP6;
          skip_remaining_next = FIXED_SKIP;
          check_trunc         = 1'b1;
        end
      end
      PH_SKIP6, PH_EXTRA, PH_HCRC: begin
        skip_remaining_next = skip_dec;
        check_trunc         = 1'b1;
        if (skip_dec == 16'd0) begin
          if (phase == PH_SKIP6) begin
            part = enter_part(3'd0, saved_flags);
          end else if (phase == PH_EXTRA) begin
            part = enter_part(3'd1, saved_flags);
          end else begin
            part = enter_part(3'd4, saved_flags);
          end
          phase_next = part.phase;
          if (part.done) final_status_next = ST_OK;
          if (part.load_crc) skip_remaining_next = HCRC_SKIP;
        end
      end
      PH_XLEN_LO: begin
        skip_remaining_next = {8'd0, in_byte};
        phase_next          = PH_XLEN_HI;
        check_trunc         = 1'b1;
      end
      PH_XLEN_HI: begin
        skip_remaining_next = {in_byte, skip_remaining[7:0]};
        check_trunc         = 1'b1;
        if ({in_byte, skip_remaining[7:0]} == 16'd0) begin
          part       = enter_part(3'd1, saved_flags);
          phase_next = part.phase;
          if (part.done) final_status_next = ST_OK;
          if (part.load_crc) skip_remaining_next = HCRC_SKIP;
        end else begin
          phase_next = PH_EXTRA;
        end
      end
      PH_NAME, PH_COMMENT: begin
        check_trunc = 1'b1;
        if (in_byte == 8'd0) begin
          part       = enter_part((phase == PH_NAME) ? 3'd2 : 3'd3, saved_flags);
          phase_next = part.phase;
          if (part.done) final_status_next = ST_OK;
          if (part.load_crc) skip_remaining_next = HCRC_SKIP;
        end
      end
      default: begin
        phase_next   = PH_ERROR;
        q_entry.kind = KIND_DISCARD;
      end
    endcase

    // Input that ends while still inside the header is truncated.
    if (check_trunc && final_status_next == ST_HEADER && end_of_input) begin
      phase_next        = PH_ERROR;
      final_status_next = ST_TRUNC;
    end

    q_entry.status = final_status_next;
    q_entry.flags  = saved_flags_next;
  end

  // Parse state advances on every accepted transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_MAGIC1;
      saved_flags    <= 5'd0;
      skip_remaining <= 16'd0;
      final_status   <= ST_HEADER;
    end else if (q_push) begin
      phase          <= phase_next;
      saved_flags    <= saved_flags_next;
      skip_remaining <= skip_remaining_next;
      final_status   <= final_status_next;
    end
  end

endmodule

[rtl/core/gzhp_queue.sv]
`timescale 1ns / 1ps

module gzhp_queue
  import gzhp_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  gzhp_entry_t din,
  output logic        full,
  input  logic        pop,
  output gzhp_entry_t dout,
  output logic        empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  gzhp_entry_t      slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign dout  = slots[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/core/gzhp_back.sv]
`timescale 1ns / 1ps

module gzhp_back
  import gzhp_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  gzhp_entry_t   head,
  input  logic          empty,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output byte_kind_t    byte_kind,
  output parse_status_t parse_status,
  output logic [4:0]    header_flag_bits,
  output logic          run_last
);

  logic load;
  logic second_pending;

  // The output register can take a new transfer when empty or draining.
  assign load = !out_valid || out_ready;
  assign pop  = load && !empty && (second_pending || !head.dup);

  // Control: output valid and the second half of a two-transfer entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      second_pending <= 1'b0;
    end else if (load) begin
      out_valid <= !empty;
      if (second_pending) begin
        second_pending <= 1'b0;
      end else if (!empty && head.dup) begin
        second_pending <= 1'b1;
      end
    end
  end

  // Payload of the output register.
  always_ff @(posedge clk) begin
    if (load && !empty) begin
      byte_kind        <= head.kind;
      parse_status     <= head.status;
      header_flag_bits <= head.flags;
      if (head.dup && !second_pending) begin
        out_byte <= MAGIC_ID1;
        run_last <= 1'b0;
      end else begin
        out_byte <= head.data;
        run_last <= 1'b1;
      end
    end
  end

endmodule

[rtl/core/gzip_header_parser.sv]
// gzip member header parser. Bytes arrive one per transfer on the slave side,
// with tlast marking the end of the buffer, and leave on the master side
// classified as header, payload or discarded, together with the running parse
// status and the low five flag bits. Throughput is one byte per cycle while
// the queue has room and the master side is not stalled; a stream whose
// second byte breaks the magic number produces two output transfers for that
// byte (the held 0x1f, then the byte). A small queue (QUEUE_DEPTH entries)
// between the classifier and the output stage absorbs that extra transfer
// and downstream backpressure, so input is accepted while results wait.
// An accepted byte is written to the queue, then to the output register.
`timescale 1ns / 1ps

module gzip_header_parser
  import gzhp_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tlast,   // end_of_input
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] out_byte, [10:8] parse_status,
                                 // [15:11] header_flag_bits
  output logic [1:0]  m_tuser,   // [1:0] byte_kind
  output logic        m_tlast    // run_last
);

  gzhp_entry_t   push_entry, head_entry;
  logic          q_push, q_pop, q_full, q_empty;
  logic [7:0]    out_byte;
  byte_kind_t    byte_kind;
  parse_status_t parse_status;
  logic [4:0]    header_flag_bits;

  // Classifier: runs the header state machine on each accepted byte.
  gzhp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .in_byte      (s_tdata),
    .end_of_input (s_tlast),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_entry      (push_entry)
  );

  // Queue of classified bytes.
  gzhp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (push_entry),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (head_entry),
    .empty (q_empty)
  );

  // Output stage: expands entries into output transfers.
  gzhp_back u_back (
    .clk              (clk),
    .rst              (rst),
    .head             (head_entry),
    .empty            (q_empty),
    .pop              (q_pop),
    .out_valid        (m_tvalid),
    .out_ready        (m_tready),
    .out_byte         (out_byte),
    .byte_kind        (byte_kind),
    .parse_status     (parse_status),
    .header_flag_bits (header_flag_bits),
    .run_last         (m_tlast)
  );

  assign m_tdata = {header_flag_bits, parse_status, out_byte};
  assign m_tuser = byte_kind;

endmodule

[rtl/core/gzhp_checker.sv]
`timescale 1ns / 1ps

module gzhp_checker
  import gzhp_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);

  // A stalled output transfer holds its contents.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("output transfer changed while stalled");

  // Only the replayed first magic byte may end without tlast.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tdata[7:0] == MAGIC_ID1 && m_tuser == KIND_PAYLOAD
      && m_tdata[10:8] == ST_TRANSP)
    else $error("unexpected non-final transfer");

  // Payload never carries the in-header status.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_PAYLOAD |-> m_tdata[10:8] != ST_HEADER)
    else $error("payload byte while header still open");

  // Discarded bytes only follow an error or a truncation.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_DISCARD |-> m_tdata[10:8] == ST_BAD
      || m_tdata[10:8] == ST_TRUNC)
    else $error("discarded byte without error status");

endmodule

bind gzip_header_parser gzhp_checker u_gzhp_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
